// ===== sv/damped_sine_shake_offset_top_assert.svh =====
// Assertion macros for the damped sine shake offset generator
`ifndef DAMPED_SINE_SHAKE_OFFSET_TOP_ASSERT_SVH
`define DAMPED_SINE_SHAKE_OFFSET_TOP_ASSERT_SVH

// same-cycle implication
`define DSSO_CHECK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DSSO_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication with a delayed consequent
`define DSSO_CHECK_LATER(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ===== sv/dsso_pkg.sv =====
// Package: types, constants and sine table for the damped sine shake offset generator
`default_nettype none

package dsso_pkg;

    localparam int ANGLE_STEPS = 1024;
    localparam int PHASE_W     = $clog2(ANGLE_STEPS);
    localparam int QUARTER     = ANGLE_STEPS / 4;
    localparam int QIDX_W      = $clog2(QUARTER + 1);
    localparam int MAG_W       = 17;
    localparam int SINE_W      = MAG_W + 1;

    localparam int ENERGY_W    = 31;
    localparam int AMP_W       = 15;
    localparam int OFFSET_W    = 16;
    localparam int PROD_W      = SINE_W + AMP_W + 1;

    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 2;

    localparam int Q_DEPTH     = 2;
    localparam int QPTR_W      = $clog2(Q_DEPTH);
    localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_Y_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP_Y  = 2'd2;

    localparam logic [CFG_W-1:0] PHASE_Y_START_RST = 10'd256;
    localparam logic [CFG_W-1:0] PHASE_STEP_X_RST  = 10'd64;
    localparam logic [CFG_W-1:0] PHASE_STEP_Y_RST  = 10'd96;

    localparam logic [63:0] PI_HALF_Q61 = 64'd3622009729038561421;
    localparam logic [63:0] X_UNIT_HI   = PI_HALF_Q61 / ANGLE_STEPS;
    localparam logic [63:0] X_UNIT_LO   = PI_HALF_Q61 % ANGLE_STEPS;

    typedef struct packed {
        logic               fin;
        logic [PHASE_W-1:0] phase_x;
        logic [PHASE_W-1:0] phase_y;
        logic [AMP_W-1:0]   amp;
    } shake_cmd_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] offset_x;
        logic signed [OFFSET_W-1:0] offset_y;
        logic                       finished;
    } shake_res_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef logic [MAG_W-1:0] sine_tab_t [QUARTER+1];

    function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[124:61];
    endfunction

    // shift-subtract unsigned division, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter wave magnitudes, index QUARTER is the peak
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   t;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        logic [63:0] div;
        for (int i = 0; i <= QUARTER; i++) begin
            a    = 64'(4 * i);
            x    = X_UNIT_HI * a + ((X_UNIT_LO * a) >> PHASE_W);
            x2   = mul_q61(x, x);
            sum  = x;
            term = x;
            for (int k = 1; k < 40; k++) begin
                if (term != 64'd0) begin
                    div  = 64'((2 * k) * (2 * k + 1));
                    term = udiv64(mul_q61(term, x2), div);
                    if ((k % 2) == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
            end
            r    = (sum + (64'd1 << 44)) >> 45;
            t[i] = r[MAG_W-1:0];
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    function automatic logic signed [SINE_W-1:0] sine_of(input logic [PHASE_W-1:0] p);
        logic [1:0]          quad;
        logic [QIDX_W-1:0]   idx;
        logic [SINE_W-1:0]   mag;
        quad = p[PHASE_W-1 -: 2];
        if (quad[0])
            idx = QIDX_W'(QUARTER) - QIDX_W'(p[PHASE_W-3:0]);
        else
            idx = QIDX_W'(p[PHASE_W-3:0]);
        mag = {1'b0, SINE_TAB[idx]};
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

// ===== sv/dsso_front.sv =====
// Front end: config registers, shake state, item classification
`default_nettype none

module dsso_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    input  wire logic                             command,
    input  wire logic [dsso_pkg::ENERGY_W-1:0]    start_energy,
    input  wire logic [dsso_pkg::ENERGY_W-1:0]    decay_rate,
    input  wire logic                             wr_en,
    input  wire logic [dsso_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [dsso_pkg::CFG_W-1:0]       wr_data,
    input  wire dsso_pkg::queue_status_t          q_status,
    output logic                                  cmd_push,
    output dsso_pkg::shake_cmd_t                  cmd_data
);
    import dsso_pkg::*;

    logic [CFG_W-1:0]    phase_y_start_reg;
    logic [CFG_W-1:0]    phase_step_x_reg;
    logic [CFG_W-1:0]    phase_step_y_reg;
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [ENERGY_W-1:0] decay_reg, decay_next;
    logic [PHASE_W-1:0]  phase_x_reg, phase_x_next;
    logic [PHASE_W-1:0]  phase_y_reg, phase_y_next;
    logic [ENERGY_W:0]   diff;
    logic                fin;
    logic                accept;

    assign accept = push && !q_status.full;
    assign diff   = {1'b0, energy_reg} - {1'b0, decay_reg};
    assign fin    = diff[ENERGY_W] || (diff == '0);

    always_comb
    begin
        energy_next  = energy_reg;
        decay_next   = decay_reg;
        phase_x_next = phase_x_reg;
        phase_y_next = phase_y_reg;
        cmd_push     = 1'b0;
        if (accept) begin
            if (command == CMD_BEGIN) begin
                phase_x_next = '0;
                phase_y_next = PHASE_W'(phase_y_start_reg % ANGLE_STEPS);
                energy_next  = start_energy;
                decay_next   = decay_rate;
            end else begin
                cmd_push = 1'b1;
                if (fin) begin
                    energy_next = '0;
                end else begin
                    energy_next  = diff[ENERGY_W-1:0];
                    phase_x_next = phase_x_reg + PHASE_W'(phase_step_x_reg % ANGLE_STEPS);
                    phase_y_next = phase_y_reg + PHASE_W'(phase_step_y_reg % ANGLE_STEPS);
                end
            end
        end
    end

    always_comb
    begin
        cmd_data.fin     = fin;
        cmd_data.phase_x = phase_x_next;
        cmd_data.phase_y = phase_y_next;
        cmd_data.amp     = diff[ENERGY_W-1 -: AMP_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_y_start_reg <= PHASE_Y_START_RST;
            phase_step_x_reg  <= PHASE_STEP_X_RST;
            phase_step_y_reg  <= PHASE_STEP_Y_RST;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_PHASE_Y_START: phase_y_start_reg <= wr_data;
                REG_PHASE_STEP_X:  phase_step_x_reg  <= wr_data;
                REG_PHASE_STEP_Y:  phase_step_y_reg  <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            energy_reg  <= '0;
            decay_reg   <= '0;
            phase_x_reg <= '0;
            phase_y_reg <= '0;
        end else begin
            energy_reg  <= energy_next;
            decay_reg   <= decay_next;
            phase_x_reg <= phase_x_next;
            phase_y_reg <= phase_y_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dsso_cmd_queue.sv =====
// Short queue of tick items between front and back end
`default_nettype none

module dsso_cmd_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    wr,
    input  wire dsso_pkg::shake_cmd_t    wdata,
    input  wire logic                    rd,
    output dsso_pkg::shake_cmd_t         rdata,
    output dsso_pkg::queue_status_t      status
);
    import dsso_pkg::*;

    shake_cmd_t        mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign rdata        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr && !rd)
            cnt_next = cnt_reg + 1'b1;
        else if (rd && !wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/dsso_back.sv =====
// Back end: sine lookup, amplitude multiply, result queue
`default_nettype none

module dsso_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    input  wire dsso_pkg::shake_cmd_t  cmd_data,
    output logic                       cmd_take,
    input  wire logic                  pop,
    output logic                       empty,
    output dsso_pkg::shake_res_t       res
);
    import dsso_pkg::*;

    logic signed [SINE_W-1:0] sine_x;
    logic signed [SINE_W-1:0] sine_y;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    shake_res_t               res_new;

    shake_res_t        mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              rd;
    logic              room;

    assign sine_x = sine_of(cmd_data.phase_x);
    assign sine_y = sine_of(cmd_data.phase_y);
    assign prod_x = sine_x * $signed({1'b0, cmd_data.amp});
    assign prod_y = sine_y * $signed({1'b0, cmd_data.amp});

    always_comb
    begin
        if (cmd_data.fin) begin
            res_new.offset_x = '0;
            res_new.offset_y = '0;
        end else begin
            res_new.offset_x = prod_x[OFFSET_W+15:16];
            res_new.offset_y = prod_y[OFFSET_W+15:16];
        end
        res_new.finished = cmd_data.fin;
    end

    assign empty    = (cnt_reg == '0);
    assign rd       = pop && !empty;
    assign room     = (cnt_reg != QCNT_W'(Q_DEPTH)) || rd;
    assign cmd_take = cmd_valid && room;
    assign res      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (cmd_take)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (cmd_take && !rd)
            cnt_next = cnt_reg + 1'b1;
        else if (rd && !cmd_take)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            mem_reg[wr_ptr_reg] <= res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/damped_sine_shake_offset_top.sv =====
// Top level of the damped two-axis sine shake offset generator
//
//   channel   handshake          payload
//   input     push / full        command, start_energy, decay_rate
//   result    empty / pop        offset_x, offset_y, finished
//   config    wr_en              wr_index, wr_data
//
// One item per cycle sustained while neither queue stalls. A tick item's result reaches
// the result ports through the command queue and then the result queue: the front updates
// state and queues the tick at the accepting edge; the back takes it once the result queue
// has room and does the sine ROM lookup and multiply into it. Begin items give no result.
// Reset clears the shake state and loads the config defaults; no clearing pass.
// Two-entry queues on both sides of the back end let input and output stall apart.
`default_nettype none

`include "damped_sine_shake_offset_top_assert.svh"

module damped_sine_shake_offset_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic                                   command,
    input  wire logic [dsso_pkg::ENERGY_W-1:0]          start_energy,
    input  wire logic [dsso_pkg::ENERGY_W-1:0]          decay_rate,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed [dsso_pkg::OFFSET_W-1:0]        offset_x,
    output logic signed [dsso_pkg::OFFSET_W-1:0]        offset_y,
    output logic                                        finished,
    input  wire logic                                   wr_en,
    input  wire logic [dsso_pkg::CFG_IDX_W-1:0]         wr_index,
    input  wire logic [dsso_pkg::CFG_W-1:0]             wr_data
);
    import dsso_pkg::*;

    logic          cmd_push;
    shake_cmd_t    cmd_in;
    shake_cmd_t    cmd_out;
    queue_status_t cmdq_status;
    logic          cmd_take;
    shake_res_t    res;

    dsso_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .command      (command),
        .start_energy (start_energy),
        .decay_rate   (decay_rate),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .q_status     (cmdq_status),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_in)
    );

    dsso_cmd_queue u_cmd_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (cmd_push),
        .wdata  (cmd_in),
        .rd     (cmd_take),
        .rdata  (cmd_out),
        .status (cmdq_status)
    );

    dsso_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmdq_status.empty),
        .cmd_data  (cmd_out),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign full     = cmdq_status.full;
    assign offset_x = res.offset_x;
    assign offset_y = res.offset_y;
    assign finished = res.finished;

    `DSSO_CHECK_IMPLY(a_fin_zero, !empty && finished, offset_x == '0 && offset_y == '0, "finished item with nonzero offset")
    `DSSO_CHECK_NEXT(a_begin_silent, push && !full && command == CMD_BEGIN && cmdq_status.empty && empty, empty, "begin item produced a result")
    `DSSO_CHECK_LATER(a_tick_latency, push && !full && command == CMD_TICK && cmdq_status.empty && empty, !empty, "tick item result missing")

endmodule

`default_nettype wire
